[src/alawff_pkg.sv]
// ----------------------------------------------------------------------------
// alawff_pkg
// Shared types, codes and the A-law expansion for the talkback frame buffer.
// ----------------------------------------------------------------------------
package alawff_pkg;

    localparam int BEAT_LANES  = 8;
    localparam int LANE_W      = 3;
    localparam int SAMPLE_W    = 16;
    localparam int KIND_W      = 2;
    localparam int CODE_W      = 8;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [KIND_W-1:0]   kind_t;

    localparam kind_t KIND_PUSH  = 2'd0;
    localparam kind_t KIND_PULL  = 2'd1;
    localparam kind_t KIND_START = 2'd2;
    localparam kind_t KIND_STOP  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // G.711 A-law expansion to 16-bit two's complement
    function automatic sample_t alaw_expand(input logic [CODE_W-1:0] code);
        logic [7:0]  a;
        logic [2:0]  seg;
        logic [15:0] mag;
        a   = code ^ 8'h55;
        seg = a[6:4];
        if (seg == 3'd0)
        begin
            mag = {8'd0, a[3:0], 4'h8};
        end
        else
        begin
            mag = ({8'd0, a[3:0], 4'h0} + 16'h0108) << (seg - 3'd1);
        end
        if (a[7])
        begin
            return mag;
        end
        return 16'h0000 - mag;
    endfunction

endpackage

[src/alawff_ram.sv]
// ----------------------------------------------------------------------------
// alawff_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module alawff_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1280
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/alaw_decode_frame_fifo.sv]
// ----------------------------------------------------------------------------
// alaw_decode_frame_fifo
// A-law decoder feeding a circular sample ring, drained in frames of beats.
// ----------------------------------------------------------------------------
// Push, start and stop items, and a pull that finds less than a frame stored
// or a disabled buffer, are handled in ST_IDLE. A pull that finds a whole
// frame emits ceil(FRAME_SAMPLES/8) beats; each beat passes through ST_FILL,
// which reads the ring one sample per cycle through its single read port,
// ST_DRAIN, which captures the last read, and ST_OUT, which holds the beat on
// the output until it is taken. The input is stalled for the whole pull.
// The ring keeps one slot empty, so it holds FRAME_SAMPLES*RING_FRAMES-1
// samples at most; a push into a full ring is dropped.
// ----------------------------------------------------------------------------
module alaw_decode_frame_fifo #(
    parameter int FRAME_SAMPLES = 320,
    parameter int RING_FRAMES   = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  alawff_pkg::kind_t       kind,
    input  logic [7:0]              alaw_byte,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [15:0]      sample_0,
    output logic signed [15:0]      sample_1,
    output logic signed [15:0]      sample_2,
    output logic signed [15:0]      sample_3,
    output logic signed [15:0]      sample_4,
    output logic signed [15:0]      sample_5,
    output logic signed [15:0]      sample_6,
    output logic signed [15:0]      sample_7,
    output logic                    last_beat
);

    import alawff_pkg::*;

    localparam int RING_SLOTS = FRAME_SAMPLES * RING_FRAMES;
    localparam int PW         = $clog2(RING_SLOTS);
    localparam int TW         = $clog2(FRAME_SAMPLES + 1);

    state_t              state_reg, state_next;
    logic [PW-1:0]       rd_pos_reg, rd_pos_next;
    logic [PW-1:0]       wr_pos_reg, wr_pos_next;
    logic                en_reg, en_next;
    logic [TW-1:0]       taken_reg, taken_next;
    logic [LANE_W-1:0]   lane_reg, lane_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                pend_pad_reg, pend_pad_next;
    logic [LANE_W-1:0]   pend_lane_reg, pend_lane_next;
    sample_t             beat_reg [BEAT_LANES];
    sample_t             beat_next [BEAT_LANES];

    logic                in_xfer;
    logic                out_xfer;
    logic [PW-1:0]       stored;
    logic [PW:0]         stored_wrap;
    logic                ring_full;
    logic                frame_ready;
    logic                pad;
    logic                ram_we;
    logic                ram_re;
    sample_t             ram_rdata;
    logic                frame_done;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    // occupancy of the ring, modulo its size
    assign stored_wrap = {1'b0, wr_pos_reg} + (PW+1)'(RING_SLOTS) - {1'b0, rd_pos_reg};
    assign stored      = (wr_pos_reg >= rd_pos_reg) ? (wr_pos_reg - rd_pos_reg)
                                                    : stored_wrap[PW-1:0];
    assign ring_full   = stored >= PW'(RING_SLOTS - 1);
    assign frame_ready = stored >= PW'(FRAME_SAMPLES);
    assign pad         = taken_reg >= TW'(FRAME_SAMPLES);
    assign frame_done  = taken_reg == TW'(FRAME_SAMPLES);

    alawff_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_SLOTS)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_pos_reg),
        .wr_data (alaw_expand(alaw_byte)),
        .rd_en   (ram_re),
        .rd_addr (rd_pos_reg),
        .rd_data (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && kind == KIND_PULL && en_reg && frame_ready)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (lane_reg == LANE_W'(BEAT_LANES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_xfer)
                begin
                    state_next = frame_done ? ST_IDLE : ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and ring controls
    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                ram_we   = in_valid && kind == KIND_PUSH && en_reg && !ring_full;
            end
            ST_FILL:
            begin
                ram_re = !pad;
            end
            ST_DRAIN:
            begin
                ram_re = 1'b0;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        rd_pos_next     = rd_pos_reg;
        wr_pos_next     = wr_pos_reg;
        en_next         = en_reg;
        taken_next      = taken_reg;
        lane_next       = lane_reg;
        pend_valid_next = 1'b0;
        pend_pad_next   = pad;
        pend_lane_next  = lane_reg;
        for (int i = 0; i < BEAT_LANES; i++)
        begin
            beat_next[i] = beat_reg[i];
        end

        if (in_xfer)
        begin
            case (kind)
                KIND_START:
                begin
                    rd_pos_next = '0;
                    wr_pos_next = '0;
                    en_next     = 1'b1;
                end
                KIND_STOP:
                begin
                    en_next = 1'b0;
                end
                KIND_PULL:
                begin
                    taken_next = '0;
                    lane_next  = '0;
                end
                default:
                begin
                    if (ram_we)
                    begin
                        wr_pos_next = (wr_pos_reg == PW'(RING_SLOTS - 1)) ? '0
                                                                          : wr_pos_reg + 1'b1;
                    end
                end
            endcase
        end

        if (state_reg == ST_FILL)
        begin
            pend_valid_next = 1'b1;
            lane_next       = lane_reg + 1'b1;
            if (!pad)
            begin
                taken_next  = taken_reg + 1'b1;
                rd_pos_next = (rd_pos_reg == PW'(RING_SLOTS - 1)) ? '0 : rd_pos_reg + 1'b1;
            end
        end

        // read data lands in the cycle after the read is issued
        if (pend_valid_reg)
        begin
            beat_next[pend_lane_reg] = pend_pad_reg ? '0 : ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_pos_reg     <= '0;
            wr_pos_reg     <= '0;
            en_reg         <= 1'b0;
            taken_reg      <= '0;
            lane_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_pos_reg     <= rd_pos_next;
            wr_pos_reg     <= wr_pos_next;
            en_reg         <= en_next;
            taken_reg      <= taken_next;
            lane_reg       <= lane_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_pad_reg  <= pend_pad_next;
        pend_lane_reg <= pend_lane_next;
        for (int i = 0; i < BEAT_LANES; i++)
        begin
            beat_reg[i] <= beat_next[i];
        end
    end

    assign sample_0  = beat_reg[0];
    assign sample_1  = beat_reg[1];
    assign sample_2  = beat_reg[2];
    assign sample_3  = beat_reg[3];
    assign sample_4  = beat_reg[4];
    assign sample_5  = beat_reg[5];
    assign sample_6  = beat_reg[6];
    assign sample_7  = beat_reg[7];
    assign last_beat = frame_done;

`ifndef SYNTHESIS
    // no input transfer while a beat is on offer
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while a beat is pending");

    // a real ring read only ever reaches a stored sample
    a_read_stored: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (stored != '0))
        else $error("ring read with nothing stored");

    // the final beat returns the block to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && last_beat) |=> (state_reg == ST_IDLE))
        else $error("frame did not end after the final beat");

    // a push into a full ring leaves the write position alone
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && kind == KIND_PUSH && ring_full) |=> $stable(wr_pos_reg))
        else $error("push accepted into a full ring");

    // a started pull always has a whole frame available
    a_pull_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && state_next == ST_FILL) |-> frame_ready)
        else $error("pull started without a whole frame");
`endif

endmodule
